// ----- sv/separable_abs_gradient_filter_top_defines.svh -----
// ----------------------------------------------------------------------------
// separable_abs_gradient_filter_top_defines: assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SEPARABLE_ABS_GRADIENT_FILTER_TOP_DEFINES_SVH
`define SEPARABLE_ABS_GRADIENT_FILTER_TOP_DEFINES_SVH

// same-cycle implication
`define SAGF_ASSERT_SAME(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define SAGF_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- sv/sagf_pkg.sv -----
// ----------------------------------------------------------------------------
// sagf_pkg: shared types and constants
// Register indexes, field widths, position control bundle and the
// per-channel absolute difference used by both filter passes.
// ----------------------------------------------------------------------------
package sagf_pkg;

	localparam int WIDTH_BITS    = 12;
	localparam int HEIGHT_BITS   = 16;
	localparam int CFG_DATA_BITS = 16;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CHANNELS      = 3;

	localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_HAS_ALPHA    = 2'd2;

	localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 12'd640;
	localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd480;

	// packed pixel: alpha, blue, green, red from msb down
	typedef logic [31:0] pix_t;

	typedef struct packed {
		logic in_frame;
		logic ignore;
		logic h_do;
		logic emit;
		logic edge_col;
		logic bnd_row;
		logic fend;
	} pos_ctl_t;

	// colour bytes get |a - b|, alpha byte comes from keep
	function automatic pix_t chan_absdiff(pix_t a, pix_t b, pix_t keep);
		pix_t       r;
		logic [7:0] ca;
		logic [7:0] cb;
		r = {keep[31:24], 24'd0};
		for (int k = 0; k < CHANNELS; k++) begin
			ca = a[8*k +: 8];
			cb = b[8*k +: 8];
			r[8*k +: 8] = (ca > cb) ? (ca - cb) : (cb - ca);
		end
		return r;
	endfunction

endpackage

// ----- sv/separable_abs_gradient_filter_top.sv -----
// ----------------------------------------------------------------------------
// separable_abs_gradient_filter_top: streaming central-difference edge filter
// One beat per cycle unless the output stalls; row store read then write. A pixel's
// result passes s1 and output register once beat W+1 later is taken, W = image width.
// Reset restores register defaults, clears position and pixel window; row stores stay.
// ----------------------------------------------------------------------------
module separable_abs_gradient_filter_top #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [sagf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [sagf_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               command,
	input  logic [7:0]                         red_in,
	input  logic [7:0]                         green_in,
	input  logic [7:0]                         blue_in,
	input  logic [7:0]                         alpha_in,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [7:0]                         red_out,
	output logic [7:0]                         green_out,
	output logic [7:0]                         blue_out,
	output logic [7:0]                         alpha_out,
	output logic                               frame_end
);

	import sagf_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	logic [WIDTH_BITS-1:0]  width_q;
	logic [HEIGHT_BITS-1:0] height_q;
	logic                   alpha_q;

	pix_t win0_q;
	pix_t win1_q;

	pos_ctl_t      ctl;
	logic [CW-1:0] pc;
	logic          in_fire;
	pix_t          px;
	pix_t          hval;

	logic          valid_s1;
	logic          we_s1;
	logic          emit_s1;
	logic          bnd_s1;
	logic          fend_s1;
	logic [CW-1:0] addr_s1;
	pix_t          hval_s1;
	logic          byp_s1;
	logic [63:0]   bypd_s1;

	logic [63:0]   rd_data;
	logic [63:0]   mem_word;
	logic [63:0]   wr_data;
	pix_t          older;
	pix_t          newer;
	pix_t          res;
	logic          s1_fire;
	logic          ram_we;
	logic          byp;

	logic          out_valid_q;
	pix_t          res_q;
	logic          fend_q;
	logic          out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			alpha_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data[WIDTH_BITS-1:0];
				CFG_IMAGE_HEIGHT: height_q <= cfg_data[HEIGHT_BITS-1:0];
				CFG_HAS_ALPHA:    alpha_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign in_fire = in_valid && in_ready;

	sagf_pos #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_pos (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (in_fire),
		.command      (command),
		.image_width  (width_q),
		.image_height (height_q),
		.ctl          (ctl),
		.pc           (pc)
	);

	// horizontal pass: the beat before this one completes now
	always_comb begin
		px   = ctl.in_frame ? {(alpha_q ? alpha_in : 8'd0), blue_in, green_in, red_in} : '0;
		hval = ctl.edge_col ? win0_q : chan_absdiff(px, win1_q, win0_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win0_q <= '0;
			win1_q <= '0;
		end else if (in_fire && ctl.in_frame && !ctl.ignore) begin
			win1_q <= win0_q;
			win0_q <= px;
		end
	end

	// row store word: older row in the upper half, newer row in the lower half
	assign ram_we  = s1_fire && we_s1;
	assign wr_data = {newer, hval_s1};
	assign byp     = ram_we && (addr_s1 == pc);

	sagf_ram #(
		.WIDTH(64),
		.DEPTH(MAX_WIDTH)
	) u_rows (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_s1),
		.wdata (wr_data),
		.re    (in_fire),
		.raddr (pc),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			we_s1    <= 1'b0;
			emit_s1  <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= ctl.h_do || ctl.emit;
			we_s1    <= ctl.h_do;
			emit_s1  <= ctl.emit;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			bnd_s1  <= ctl.bnd_row;
			fend_s1 <= ctl.fend;
			addr_s1 <= pc;
			hval_s1 <= hval;
			byp_s1  <= byp;
			bypd_s1 <= wr_data;
		end
	end

	// vertical pass
	always_comb begin
		mem_word = byp_s1 ? bypd_s1 : rd_data;
		older    = mem_word[63:32];
		newer    = mem_word[31:0];
		res      = bnd_s1 ? newer : chan_absdiff(older, hval_s1, newer);
	end

	assign out_free = !out_valid_q || out_ready;
	assign s1_fire  = valid_s1 && (!emit_s1 || out_free);
	assign in_ready = !valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && emit_s1) begin
			res_q  <= res;
			fend_q <= fend_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign red_out   = res_q[7:0];
	assign green_out = res_q[15:8];
	assign blue_out  = res_q[23:16];
	assign alpha_out = res_q[31:24];
	assign frame_end = fend_q;

endmodule

// ----- sv/sagf_ram.sv -----
// ----------------------------------------------------------------------------
// sagf_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; a read of the address being
// written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module sagf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2048,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/sagf_pos.sv -----
// ----------------------------------------------------------------------------
// sagf_pos: raster position tracking
// Holds column and row of the incoming beat and decodes which column
// completes, whether a result leaves, and the border cases of both passes.
// ----------------------------------------------------------------------------
module sagf_pos #(
	parameter int MAX_WIDTH = 2048,
	localparam int CW       = $clog2(MAX_WIDTH)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             step,
	input  logic                             command,
	input  logic [sagf_pkg::WIDTH_BITS-1:0]  image_width,
	input  logic [sagf_pkg::HEIGHT_BITS-1:0] image_height,
	output sagf_pkg::pos_ctl_t               ctl,
	output logic [CW-1:0]                    pc
);

	import sagf_pkg::*;

	localparam int RW = HEIGHT_BITS + 1;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	logic [CW:0]   w_eff;
	logic [CW:0]   w_m1;
	logic [RW-1:0] h_eff;
	logic          restart;
	logic [CW-1:0] c;
	logic [RW-1:0] r;
	logic [RW-1:0] pr;
	logic [RW-1:0] orow;
	logic          have_prev;
	logic [CW:0]   c_inc;

	always_comb begin
		if (image_width == '0) begin
			w_eff = (CW+1)'(1);
		end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
			w_eff = (CW+1)'(MAX_WIDTH);
		end else begin
			w_eff = (CW+1)'(image_width);
		end
		w_m1  = w_eff - (CW+1)'(1);
		h_eff = (image_height == '0) ? RW'(1) : {1'b0, image_height};

		// counters outside the current bounds start a new frame
		restart = ({1'b0, col_q} >= w_eff) || (row_q > h_eff + RW'(1));
		c = restart ? '0 : col_q;
		r = restart ? '0 : row_q;

		have_prev = (r != '0) || (c != '0);
		pc = (c != '0) ? (c - CW'(1)) : w_m1[CW-1:0];
		pr = (c != '0) ? r : (r - RW'(1));
		orow = pr - RW'(1);
		c_inc = {1'b0, c} + (CW+1)'(1);

		ctl.in_frame = r < h_eff;
		ctl.ignore   = ctl.in_frame && command;
		ctl.h_do     = !ctl.ignore && have_prev && (pr < h_eff);
		ctl.emit     = !ctl.ignore && have_prev && (pr >= RW'(1)) && (pr <= h_eff);
		ctl.edge_col = (pc == '0) || ({1'b0, pc} == w_m1);
		ctl.bnd_row  = (orow == '0) || (orow == h_eff - RW'(1));
		ctl.fend     = ctl.emit && (orow == h_eff - RW'(1)) && ({1'b0, pc} == w_m1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			if (ctl.ignore) begin
				col_q <= c;
				row_q <= r;
			end else if (ctl.fend) begin
				col_q <= '0;
				row_q <= '0;
			end else if (c_inc >= w_eff) begin
				col_q <= '0;
				row_q <= r + RW'(1);
			end else begin
				col_q <= c_inc[CW-1:0];
				row_q <= r;
			end
		end
	end

endmodule

// ----- sv/sagf_checker.sv -----
// ----------------------------------------------------------------------------
// sagf_checker: port-level assertions for the edge filter
// Watches the top level's handshakes and result beats over time.
// ----------------------------------------------------------------------------
`include "separable_abs_gradient_filter_top_defines.svh"

module sagf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] red_out,
	input logic [7:0] green_out,
	input logic [7:0] blue_out,
	input logic [7:0] alpha_out,
	input logic       frame_end
);

	// a stalled result beat holds
	`SAGF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable({red_out, green_out, blue_out, alpha_out, frame_end}),
		"result beat changed while stalled")

	// with room at the output the input side never stalls
	`SAGF_ASSERT_SAME(a_in_ready_free, !out_valid || out_ready, in_ready,
		"input stalled although output register is free")

	// a new result beat follows from an input beat that passed the s1 and output registers
	`SAGF_ASSERT_SAME(a_out_cause, $rose(out_valid), $past(in_valid && in_ready, 2),
		"result beat without a matching input beat")

endmodule

bind separable_abs_gradient_filter_top sagf_checker u_sagf_checker (.*);
